// ===== src/ttd_pkg.sv =====
// ttd_pkg: shared types, codes and channel expansion tables for the texel decoder
// used by ttd_place, ttd_direct and twiddled_texture_texel_decoder_core
`timescale 1ns / 1ps
`default_nettype none

package ttd_pkg;

    // field widths fixed by the stream format
    localparam int ADDR_W       = 20;
    localparam int TEXEL_W      = 16;
    localparam int PIXEL_W      = 32;
    localparam int PAL_IDX_W    = 8;
    localparam int STATUS_W     = 2;
    localparam int FMT_W        = 3;
    localparam int DIM_W        = 4;
    localparam int COUNT_W      = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 56;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_ARGB1555 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_ARGB4444 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_PAL4     = 3'd5;
    localparam logic [FMT_W-1:0] FMT_PAL8     = 3'd6;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd2;

    // input word kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_TEXEL   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd4;

    // texture geometry handed to the address unit
    typedef struct packed {
        logic             twiddled;
        logic [DIM_W-1:0] width_log2;
        logic [DIM_W-1:0] height_log2;
    } geom_t;

    // v*255/31 truncated, one byte per code
    function automatic logic [32*8-1:0] exp5_build();
        logic [32*8-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < 32; i++)
        begin
            tbl[i*8 +: 8] = 8'((i * 255) / 31);
        end
        return tbl;
    endfunction

    // v*255/63 truncated, one byte per code
    function automatic logic [64*8-1:0] exp6_build();
        logic [64*8-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < 64; i++)
        begin
            tbl[i*8 +: 8] = 8'((i * 255) / 63);
        end
        return tbl;
    endfunction

    localparam logic [32*8-1:0] EXP5_TABLE = exp5_build();
    localparam logic [64*8-1:0] EXP6_TABLE = exp6_build();

endpackage

`default_nettype wire

// ===== src/ttd_place.sv =====
// ttd_place: texel number to output pixel index, with twiddle de-interleave
// depends on ttd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttd_place #(
    parameter int MAX_DIM_LOG2 = 10
) (
    input  wire ttd_pkg::geom_t                 geom,
    input  wire logic [ttd_pkg::ADDR_W-1:0]     texel_number,
    output logic      [ttd_pkg::ADDR_W-1:0]     address
);

    localparam int EXT_W  = (2 * MAX_DIM_LOG2 > ttd_pkg::ADDR_W) ?
                            2 * MAX_DIM_LOG2 : ttd_pkg::ADDR_W;
    localparam int EXT_IW = $clog2(EXT_W);
    localparam logic [ttd_pkg::DIM_W-1:0] MAX_DIM = ttd_pkg::DIM_W'(MAX_DIM_LOG2);

    logic [EXT_W-1:0]           src;
    logic [ttd_pkg::DIM_W-1:0]  rows;
    logic [ttd_pkg::DIM_W-1:0]  cols;
    logic [ttd_pkg::DIM_W-1:0]  common;
    logic [MAX_DIM_LOG2-1:0]    row;
    logic [MAX_DIM_LOG2-1:0]    col;
    logic [ttd_pkg::ADDR_W-1:0] row_ext;
    logic [ttd_pkg::ADDR_W-1:0] col_ext;

    assign src    = EXT_W'(texel_number);
    assign rows   = (geom.width_log2  > MAX_DIM) ? MAX_DIM : geom.width_log2;
    assign cols   = (geom.height_log2 > MAX_DIM) ? MAX_DIM : geom.height_log2;
    assign common = (rows < cols) ? rows : cols;

    // interleaved part: row takes even bits, col odd bits; past the shorter
    // side the longer one takes the remaining bits in a run
    always_comb
    begin
        for (int k = 0; k < MAX_DIM_LOG2; k++)
        begin
            if (k >= int'(rows))
                row[k] = 1'b0;
            else if (k < int'(common))
                row[k] = src[EXT_IW'(2 * k)];
            else
                row[k] = src[EXT_IW'(int'(common) + k)];

            if (k >= int'(cols))
                col[k] = 1'b0;
            else if (k < int'(common))
                col[k] = src[EXT_IW'(2 * k + 1)];
            else
                col[k] = src[EXT_IW'(int'(common) + k)];
        end
    end

    assign row_ext = ttd_pkg::ADDR_W'(row);
    assign col_ext = ttd_pkg::ADDR_W'(col);

    assign address = geom.twiddled ? ((row_ext << cols) | col_ext) : texel_number;

endmodule

`default_nettype wire

// ===== src/ttd_direct.sv =====
// ttd_direct: widens a direct-colour texel word to an rgba8888 pixel
// depends on ttd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttd_direct (
    input  wire logic [ttd_pkg::FMT_W-1:0]   texel_format,
    input  wire logic [ttd_pkg::TEXEL_W-1:0] texel,
    output logic      [ttd_pkg::PIXEL_W-1:0] pixel_rgba
);

    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;

    always_comb
    begin
        unique case (texel_format)
            ttd_pkg::FMT_ARGB1555:
            begin
                a = texel[15] ? 8'hFF : 8'h00;
                r = ttd_pkg::EXP5_TABLE[{texel[14:10], 3'b000} +: 8];
                g = ttd_pkg::EXP5_TABLE[{texel[9:5], 3'b000} +: 8];
                b = ttd_pkg::EXP5_TABLE[{texel[4:0], 3'b000} +: 8];
            end
            ttd_pkg::FMT_RGB565:
            begin
                a = 8'hFF;
                r = ttd_pkg::EXP5_TABLE[{texel[15:11], 3'b000} +: 8];
                g = ttd_pkg::EXP6_TABLE[{texel[10:5], 3'b000} +: 8];
                b = ttd_pkg::EXP5_TABLE[{texel[4:0], 3'b000} +: 8];
            end
            ttd_pkg::FMT_ARGB4444:
            begin
                // v*255/15 is v*17, i.e. the nibble repeated
                a = {texel[15:12], texel[15:12]};
                r = {texel[11:8], texel[11:8]};
                g = {texel[7:4], texel[7:4]};
                b = {texel[3:0], texel[3:0]};
            end
            default:
            begin
                a = 8'h00;
                r = 8'h00;
                g = 8'h00;
                b = 8'h00;
            end
        endcase
    end

    assign pixel_rgba = {r, g, b, a};

endmodule

`default_nettype wire

// ===== src/twiddled_texture_texel_decoder_core.sv =====
// twiddled_texture_texel_decoder_core: top level of the texel decoder
// depends on ttd_pkg, ttd_place and ttd_direct
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_* carries input words: tuser is the kind (palette write or texel word);
//   a palette write stores its colour in the on-chip palette and gives no result
//   m_* carries results: pixel index, rgba8888 pixel, status, tlast on the final
//   result of a texel word
//   cfg_* writes the format and geometry registers, one per cycle, no read-back;
//   only write them while nothing is in flight
// timing
//   a texel word's first result passes the decode stage and the output register
//   before it is on m_*; one word per cycle for direct formats and pal8 while
//   m_tready is high; a pal4 word gives two results and occupies the decode stage
//   for both, so a new word is taken only as its second result moves on
//   palette writes are visible to the very next texel
// reset and stall
//   rst_n clears the handshake state and restores the register defaults
//   (argb1555, twiddled, 8x8, 256 palette entries); palette contents are not
//   cleared and must be written before use
//   when m_tready is low the output register holds its word, the decode stage
//   still fills behind it, and s_tready drops once both are full; a pal4 word
//   also holds s_tready low while its first pixel goes out

module twiddled_texture_texel_decoder_core #(
    parameter int MAX_DIM_LOG2  = 10,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [19:0] texel_number, [35:20] texel, [43:36] palette_index,
    // [75:44] palette_color, [79:76] zero
    input  wire logic [ttd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] kind
    input  wire logic                               s_tuser,

    // result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [19:0] address, [51:20] pixel_rgba, [55:52] zero
    output logic      [ttd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic      [ttd_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                    m_tlast,

    // register writes
    input  wire logic                               cfg_we,
    input  wire logic [ttd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ttd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam logic [ttd_pkg::COUNT_W-1:0] PAL_DEPTH_C = ttd_pkg::COUNT_W'(PALETTE_DEPTH);

    // configuration registers
    logic [ttd_pkg::FMT_W-1:0]   texel_format_reg;
    logic                        twiddled_reg;
    logic [ttd_pkg::DIM_W-1:0]   width_log2_reg;
    logic [ttd_pkg::DIM_W-1:0]   height_log2_reg;
    logic [ttd_pkg::COUNT_W-1:0] palette_count_reg;

    // input word fields
    logic [ttd_pkg::ADDR_W-1:0]    in_texel_number;
    logic [ttd_pkg::TEXEL_W-1:0]   in_texel;
    logic [ttd_pkg::PAL_IDX_W-1:0] in_palette_index;
    logic [ttd_pkg::PIXEL_W-1:0]   in_palette_color;

    // palette memory
    logic [ttd_pkg::PIXEL_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [PAL_AW-1:0]           rd_addr_a;
    logic [PAL_AW-1:0]           rd_addr_b;
    logic                        pal_write;

    // decode stage
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_phase_reg;
    logic                          s1_phase_next;
    logic [ttd_pkg::ADDR_W-1:0]    s1_tn_reg;
    logic [ttd_pkg::TEXEL_W-1:0]   s1_texel_reg;
    logic [ttd_pkg::PIXEL_W-1:0]   pal_a_reg;
    logic [ttd_pkg::PIXEL_W-1:0]   pal_b_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ttd_pkg::ADDR_W-1:0]    out_address_reg;
    logic [ttd_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic [ttd_pkg::STATUS_W-1:0]  out_status_reg;
    logic                          out_last_reg;

    // handshake
    logic in_accept;
    logic texel_accept;
    logic out_free;
    logic s1_advance;
    logic s1_final;
    logic s1_done;
    logic is_pal4;

    // decode results
    ttd_pkg::geom_t                geom;
    logic [ttd_pkg::ADDR_W-1:0]    tn_sel;
    logic [ttd_pkg::ADDR_W-1:0]    place_address;
    logic [ttd_pkg::PIXEL_W-1:0]   direct_rgba;
    logic [ttd_pkg::PAL_IDX_W-1:0] lookup_index;
    logic [ttd_pkg::PIXEL_W-1:0]   lookup_entry;
    logic [ttd_pkg::COUNT_W-1:0]   palette_limit;
    logic                          lookup_ok;
    logic [ttd_pkg::PIXEL_W-1:0]   res_pixel;
    logic [ttd_pkg::STATUS_W-1:0]  res_status;
    logic                          res_last;

    assign in_texel_number  = s_tdata[19:0];
    assign in_texel         = s_tdata[35:20];
    assign in_palette_index = s_tdata[43:36];
    assign in_palette_color = s_tdata[75:44];

    //------------------------------------------------------------------
    // configuration
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_format_reg  <= ttd_pkg::FMT_ARGB1555;
            twiddled_reg      <= 1'b1;
            width_log2_reg    <= ttd_pkg::DIM_W'(3);
            height_log2_reg   <= ttd_pkg::DIM_W'(3);
            palette_count_reg <= ttd_pkg::COUNT_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttd_pkg::CFG_PIXEL_FORMAT:  texel_format_reg  <= cfg_wdata[2:0];
                ttd_pkg::CFG_TWIDDLED:      twiddled_reg      <= cfg_wdata[0];
                ttd_pkg::CFG_WIDTH_LOG2:    width_log2_reg    <= cfg_wdata[3:0];
                ttd_pkg::CFG_HEIGHT_LOG2:   height_log2_reg   <= cfg_wdata[3:0];
                ttd_pkg::CFG_PALETTE_COUNT: palette_count_reg <= cfg_wdata[8:0];
                default:                    ;  // unused index, write dropped
            endcase
        end
    end

    //------------------------------------------------------------------
    // handshake: decode stage and output register form a two-deep pipe
    //------------------------------------------------------------------
    assign is_pal4      = (texel_format_reg == ttd_pkg::FMT_PAL4);
    assign out_free     = !out_valid_reg || m_tready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign s1_final     = !is_pal4 || s1_phase_reg;   // pal4 needs a second pass
    assign s1_done      = s1_advance && s1_final;
    assign s_tready     = !s1_valid_reg || s1_done;
    assign in_accept    = s_tvalid && s_tready;
    assign texel_accept = in_accept && (s_tuser == ttd_pkg::KIND_TEXEL);
    assign pal_write    = in_accept && (s_tuser == ttd_pkg::KIND_PALETTE) &&
                          ({1'b0, in_palette_index} < PAL_DEPTH_C);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        if (texel_accept)
        begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
        else if (s1_advance)
        begin
            s1_phase_next = 1'b1;
        end

        if (s1_advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    //------------------------------------------------------------------
    // palette memory: one write port, two registered read ports; both
    // nibble lookups of a pal4 word are fetched together at accept
    //------------------------------------------------------------------
    assign rd_addr_a = (texel_format_reg == ttd_pkg::FMT_PAL8) ?
                       in_texel[PAL_AW-1:0] : PAL_AW'(in_texel[7:4]);
    assign rd_addr_b = PAL_AW'(in_texel[3:0]);

    always_ff @(posedge clk)
    begin
        if (pal_write)
            palette_mem[in_palette_index[PAL_AW-1:0]] <= in_palette_color;
        if (texel_accept)
        begin
            pal_a_reg    <= palette_mem[rd_addr_a];
            pal_b_reg    <= palette_mem[rd_addr_b];
            s1_tn_reg    <= in_texel_number;
            s1_texel_reg <= in_texel;
        end
    end

    //------------------------------------------------------------------
    // decode
    //------------------------------------------------------------------
    assign geom.twiddled    = twiddled_reg;
    assign geom.width_log2  = width_log2_reg;
    assign geom.height_log2 = height_log2_reg;

    // second pal4 pixel lands one texel further on
    assign tn_sel = s1_phase_reg ? (s1_tn_reg + ttd_pkg::ADDR_W'(1)) : s1_tn_reg;

    ttd_place #(
        .MAX_DIM_LOG2 (MAX_DIM_LOG2)
    ) u_place (
        .geom         (geom),
        .texel_number (tn_sel),
        .address      (place_address)
    );

    ttd_direct u_direct (
        .texel_format (texel_format_reg),
        .texel        (s1_texel_reg),
        .pixel_rgba   (direct_rgba)
    );

    assign palette_limit = (palette_count_reg < PAL_DEPTH_C) ? palette_count_reg : PAL_DEPTH_C;

    always_comb
    begin
        lookup_index = s1_texel_reg[7:0];
        lookup_entry = pal_a_reg;
        if (is_pal4)
        begin
            // high nibble first
            lookup_index = s1_phase_reg ? {4'h0, s1_texel_reg[3:0]} : {4'h0, s1_texel_reg[7:4]};
            lookup_entry = s1_phase_reg ? pal_b_reg : pal_a_reg;
        end
    end

    assign lookup_ok = ({1'b0, lookup_index} < palette_limit);

    always_comb
    begin
        res_last = 1'b1;
        unique case (texel_format_reg)
            ttd_pkg::FMT_ARGB1555,
            ttd_pkg::FMT_RGB565,
            ttd_pkg::FMT_ARGB4444:
            begin
                res_pixel  = direct_rgba;
                res_status = ttd_pkg::ST_OK;
            end
            ttd_pkg::FMT_PAL4,
            ttd_pkg::FMT_PAL8:
            begin
                // palette holds argb, result wants rgba
                res_pixel  = lookup_ok ? {lookup_entry[23:0], lookup_entry[31:24]} : '0;
                res_status = lookup_ok ? ttd_pkg::ST_OK : ttd_pkg::ST_RANGE;
                res_last   = s1_final;
            end
            default:
            begin
                res_pixel  = '0;
                res_status = ttd_pkg::ST_UNSUPPORTED;
            end
        endcase
    end

    //------------------------------------------------------------------
    // output register
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_address_reg <= place_address;
            out_pixel_reg   <= res_pixel;
            out_status_reg  <= res_status;
            out_last_reg    <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_pixel_reg, out_address_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
